FILE: rtl/core/gtpa_pkg.sv
// Shared types, opcodes and constants of the gated temporal pixel average core.
// No dependencies; the front, back and top files of the core import this package.
package gtpa_pkg;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_OFFER = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam int         IDX_W           = 18;
    localparam int         SUM_W           = 12;
    localparam int         CNT_W           = 4;
    localparam int         RECIP_W         = 17;
    localparam int         RECIP_SHIFT     = 16;
    localparam logic [7:0] THRESHOLD_RESET = 8'd20;

    // One request as it travels from the front part to the back part.
    typedef struct packed {
        logic [1:0]       op;
        logic [IDX_W-1:0] idx;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
    } t_cmd;

    // One per-pixel entry of the accumulation memory.
    typedef struct packed {
        logic [7:0]       ref_green;
        logic [CNT_W-1:0] count;
        logic [SUM_W-1:0] sum_b;
        logic [SUM_W-1:0] sum_g;
        logic [SUM_W-1:0] sum_r;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // ceil(2^16 / c). For any 12-bit sum, (sum * recip(c)) >> 16 equals sum / c exactly.
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] c);
        logic [RECIP_W-1:0] r;
        case (c)
            4'd1:    r = 17'd65536;
            4'd2:    r = 17'd32768;
            4'd3:    r = 17'd21846;
            4'd4:    r = 17'd16384;
            4'd5:    r = 17'd13108;
            4'd6:    r = 17'd10923;
            4'd7:    r = 17'd9363;
            4'd8:    r = 17'd8192;
            4'd9:    r = 17'd7282;
            4'd10:   r = 17'd6554;
            4'd11:   r = 17'd5958;
            4'd12:   r = 17'd5462;
            4'd13:   r = 17'd5042;
            4'd14:   r = 17'd4682;
            4'd15:   r = 17'd4370;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/core/gtpa_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module gtpa_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 262144
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/gtpa_front.sv
// Front part: takes input requests, drops those that do nothing, queues the rest.
// Depends on gtpa_pkg.
module gtpa_front
    import gtpa_pkg::*;
#(
    parameter int FRAME_PIXELS = 262144
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [1:0]       i_opcode,
    input  logic [IDX_W-1:0] i_pixel_index,
    input  logic [7:0]       i_red,
    input  logic [7:0]       i_green,
    input  logic [7:0]       i_blue,
    output logic             o_cmd_valid,
    output t_cmd             o_cmd,
    input  logic             i_pop
);

    localparam int QDEPTH = 2;

    t_cmd       r_queue [QDEPTH];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic       keep;
    logic       push;

    always_comb begin
        unique case (i_opcode) inside
            OP_LOAD, OP_OFFER, OP_READ: keep = (32'(i_pixel_index) < FRAME_PIXELS);
            default:                    keep = 1'b0;
        endcase
    end

    assign o_in_stall  = (r_count == 2'(QDEPTH));
    assign push        = i_in_valid && !o_in_stall && keep;
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_queue[r_rptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wptr] <= '{op: i_opcode, idx: i_pixel_index, red: i_red,
                                 green: i_green, blue: i_blue};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_count <= r_count + 2'(push) - 2'(i_pop);
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'(QDEPTH))
        else $error("queue count exceeds depth");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != 2'd0)
        else $error("pop from empty queue");
`endif

endmodule

FILE: rtl/core/gtpa_back.sv
// Back part: executes queued requests against the per-pixel memory and
// produces averages. Depends on gtpa_pkg and gtpa_ram.
module gtpa_back
    import gtpa_pkg::*;
#(
    parameter int FRAME_PIXELS = 262144,
    parameter int HALF_WINDOW  = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [7:0]       i_threshold,
    input  logic             i_cmd_valid,
    input  t_cmd             i_cmd,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [IDX_W-1:0] o_out_index,
    output logic [7:0]       o_avg_red,
    output logic [7:0]       o_avg_green,
    output logic [7:0]       o_avg_blue,
    output logic [CNT_W-1:0] o_used_count
);

    localparam int MEM_DEPTH = (FRAME_PIXELS < (2 ** IDX_W)) ? FRAME_PIXELS : (2 ** IDX_W);
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam logic [CNT_W-1:0] COUNT_CAP = CNT_W'(2 * HALF_WINDOW + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0]       r_state;
    logic [1:0]       n_state;
    t_cmd             r_cmd;
    logic [7:0]       r_q_red;
    logic [7:0]       r_q_green;
    logic [7:0]       r_q_blue;
    logic [CNT_W-1:0] r_q_count;
    logic             r_out_valid;
    logic [IDX_W-1:0] r_out_index;
    logic [7:0]       r_avg_red;
    logic [7:0]       r_avg_green;
    logic [7:0]       r_avg_blue;
    logic [CNT_W-1:0] r_used_count;

    logic             ram_we;
    logic             ram_re;
    logic [ADDR_W-1:0] ram_waddr;
    t_entry           ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    t_entry           entry;
    logic [7:0]       diff;
    logic             gate;
    logic [RECIP_W-1:0] rcp;
    logic [SUM_W+RECIP_W-1:0] prod_r;
    logic [SUM_W+RECIP_W-1:0] prod_g;
    logic [SUM_W+RECIP_W-1:0] prod_b;
    logic             out_free;
    logic             load_out;

    gtpa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MEM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (i_cmd.idx[ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    assign entry = t_entry'(ram_rdata);

    // Motion gate on the green channel, plus the count capacity.
    assign diff = (r_cmd.green > entry.ref_green) ? (r_cmd.green - entry.ref_green)
                                                  : (entry.ref_green - r_cmd.green);
    assign gate = (diff <= i_threshold) && (entry.count < COUNT_CAP);

    // Division by the count through an exact reciprocal.
    assign rcp    = recip(entry.count);
    assign prod_r = (SUM_W+RECIP_W)'(entry.sum_r) * (SUM_W+RECIP_W)'(rcp);
    assign prod_g = (SUM_W+RECIP_W)'(entry.sum_g) * (SUM_W+RECIP_W)'(rcp);
    assign prod_b = (SUM_W+RECIP_W)'(entry.sum_b) * (SUM_W+RECIP_W)'(rcp);

    assign out_free = !r_out_valid || !i_out_stall;
    assign load_out = (r_state == S_OUT) && out_free;

    always_comb begin
        n_state   = r_state;
        o_pop     = 1'b0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = i_cmd.idx[ADDR_W-1:0];
        ram_wdata = '{ref_green: i_cmd.green, count: CNT_W'(1),
                      sum_b: SUM_W'(i_cmd.blue), sum_g: SUM_W'(i_cmd.green),
                      sum_r: SUM_W'(i_cmd.red)};
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_pop = 1'b1;
                    if (i_cmd.op == OP_LOAD) begin
                        ram_we = 1'b1;
                    end else begin
                        ram_re  = 1'b1;
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                ram_waddr = r_cmd.idx[ADDR_W-1:0];
                ram_wdata = '{ref_green: entry.ref_green, count: entry.count + CNT_W'(1),
                              sum_b: entry.sum_b + SUM_W'(r_cmd.blue),
                              sum_g: entry.sum_g + SUM_W'(r_cmd.green),
                              sum_r: entry.sum_r + SUM_W'(r_cmd.red)};
                if (r_cmd.op == OP_OFFER) begin
                    ram_we  = gate;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        if (r_state == S_READ) begin
            r_q_red   <= prod_r[RECIP_SHIFT +: 8];
            r_q_green <= prod_g[RECIP_SHIFT +: 8];
            r_q_blue  <= prod_b[RECIP_SHIFT +: 8];
            r_q_count <= entry.count;
        end
        if (load_out) begin
            r_out_index  <= r_cmd.idx;
            r_avg_red    <= r_q_red;
            r_avg_green  <= r_q_green;
            r_avg_blue   <= r_q_blue;
            r_used_count <= r_q_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_index  = r_out_index;
    assign o_avg_red    = r_avg_red;
    assign o_avg_green  = r_avg_green;
    assign o_avg_blue   = r_avg_blue;
    assign o_used_count = r_used_count;

`ifndef SYNTHESIS
    a_port_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("memory read and write in the same cycle");
    a_out_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && $past(r_state) != S_OUT) |-> $past(r_state) == S_READ)
        else $error("output state entered without a memory read");
`endif

endmodule

FILE: rtl/core/gated_temporal_pixel_average_core.sv
// Top level of the gated temporal pixel average core: threshold register,
// front queue and back execution. Depends on gtpa_pkg, gtpa_front, gtpa_back.
//
// Usage: each input request carries an opcode, a pixel index and an RGB pixel.
// Opcode 0 loads the reference pixel of an index, opcode 1 offers a neighbour
// pixel that joins the average only when its green value lies within the
// threshold of the reference green and the count is below 2*HALF_WINDOW+1,
// and opcode 2 returns the truncated per-channel average with its count.
// Opcode 3 and indexes at or beyond FRAME_PIXELS are dropped at the front.
// Both channels use valid and stall; a request moves when valid is high and
// stall is low. The threshold is written through i_cfg_we and i_cfg_wdata.
// The back part handles one request at a time: a load is a memory write, an
// offer a memory read, then a write back, and a read a memory read, a
// reciprocal multiply and an output register, as set by the single memory
// port pair and the read-modify-write of each pixel entry. A two-entry queue
// lets the front keep accepting while the back works or the output waits
// under stall; a stalled result holds in the output register. Reset sets the
// threshold to 20 and empties the queue; the pixel memory is not cleared and
// must be loaded first.
module gated_temporal_pixel_average_core
    import gtpa_pkg::*;
#(
    parameter int FRAME_PIXELS = 262144,
    parameter int HALF_WINDOW  = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [7:0]       i_cfg_wdata,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [1:0]       i_opcode,
    input  logic [IDX_W-1:0] i_pixel_index,
    input  logic [7:0]       i_red,
    input  logic [7:0]       i_green,
    input  logic [7:0]       i_blue,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [IDX_W-1:0] o_out_index,
    output logic [7:0]       o_avg_red,
    output logic [7:0]       o_avg_green,
    output logic [7:0]       o_avg_blue,
    output logic [CNT_W-1:0] o_used_count
);

    logic [7:0] r_diff_threshold;
    logic       cmd_valid;
    t_cmd       cmd;
    logic       pop;

    // The user must change the threshold only while the core is idle; the core does not enforce this or shadow it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_diff_threshold <= THRESHOLD_RESET;
        end else if (i_cfg_we) begin
            r_diff_threshold <= i_cfg_wdata;
        end
    end

    gtpa_front #(
        .FRAME_PIXELS (FRAME_PIXELS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_opcode      (i_opcode),
        .i_pixel_index (i_pixel_index),
        .i_red         (i_red),
        .i_green       (i_green),
        .i_blue        (i_blue),
        .o_cmd_valid   (cmd_valid),
        .o_cmd         (cmd),
        .i_pop         (pop)
    );

    gtpa_back #(
        .FRAME_PIXELS (FRAME_PIXELS),
        .HALF_WINDOW  (HALF_WINDOW)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_threshold  (r_diff_threshold),
        .i_cmd_valid  (cmd_valid),
        .i_cmd        (cmd),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_index  (o_out_index),
        .o_avg_red    (o_avg_red),
        .o_avg_green  (o_avg_green),
        .o_avg_blue   (o_avg_blue),
        .o_used_count (o_used_count)
    );

endmodule

FILE: tb/gtpa_average_checker.sv
// Checker for the gated temporal pixel average core: follows the request and result
// channels and the threshold port, predicts each average and compares it field by field.
// Depends on gtpa_pkg.
module gtpa_average_checker
    import gtpa_pkg::*;
#(
    parameter int FRAME_PIXELS = 262144,
    parameter int HALF_WINDOW  = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [7:0]       i_cfg_wdata,
    input  logic             i_in_valid,
    input  logic             i_in_stall,
    input  logic [1:0]       i_opcode,
    input  logic [IDX_W-1:0] i_pixel_index,
    input  logic [7:0]       i_red,
    input  logic [7:0]       i_green,
    input  logic [7:0]       i_blue,
    input  logic             i_out_valid,
    input  logic             i_out_stall,
    input  logic [IDX_W-1:0] i_out_index,
    input  logic [7:0]       i_avg_red,
    input  logic [7:0]       i_avg_green,
    input  logic [7:0]       i_avg_blue,
    input  logic [CNT_W-1:0] i_used_count,
    output int               o_fail_count,
    output int               o_pending
);

    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic [CNT_W-1:0] count;
    } t_average;

    localparam logic [CNT_W-1:0] COUNT_CAP = CNT_W'(2 * HALF_WINDOW + 1);

    t_entry     pixel_acc [FRAME_PIXELS];
    t_average   expected_averages [$];
    logic [7:0] gate_threshold;
    int         fail_count = 0;

    assign o_fail_count = fail_count;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR at %0t: %s: got %0d, expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    // Applies one accepted request to the per-pixel accumulators and queues the
    // average that a read must return.
    function automatic void predict_average(input logic [1:0] op, input logic [IDX_W-1:0] idx,
                                            input logic [7:0] r, input logic [7:0] g,
                                            input logic [7:0] b);
        t_entry     acc;
        t_average   avg;
        logic [7:0] green_diff;
        if (idx >= FRAME_PIXELS)
            return;
        case (op)
            OP_LOAD: begin
                acc.sum_r     = SUM_W'(r);
                acc.sum_g     = SUM_W'(g);
                acc.sum_b     = SUM_W'(b);
                acc.ref_green = g;
                acc.count     = CNT_W'(1);
                pixel_acc[idx] = acc;
            end
            OP_OFFER: begin
                acc = pixel_acc[idx];
                green_diff = (g > acc.ref_green) ? g - acc.ref_green : acc.ref_green - g;
                if (green_diff <= gate_threshold && acc.count < COUNT_CAP) begin
                    acc.sum_r = acc.sum_r + SUM_W'(r);
                    acc.sum_g = acc.sum_g + SUM_W'(g);
                    acc.sum_b = acc.sum_b + SUM_W'(b);
                    acc.count = acc.count + CNT_W'(1);
                    pixel_acc[idx] = acc;
                end
            end
            OP_READ: begin
                acc = pixel_acc[idx];
                avg.index = idx;
                avg.count = acc.count;
                if (acc.count == '0) begin
                    avg.red   = '0;
                    avg.green = '0;
                    avg.blue  = '0;
                end else begin
                    avg.red   = 8'(acc.sum_r / acc.count);
                    avg.green = 8'(acc.sum_g / acc.count);
                    avg.blue  = 8'(acc.sum_b / acc.count);
                end
                expected_averages.push_back(avg);
            end
            default: ;
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_average want;
        if (!i_rst_n) begin
            gate_threshold = THRESHOLD_RESET;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_averages.size() == 0) begin
                    report_mismatch("result with no read pending, index", i_out_index, -1);
                end else begin
                    want = expected_averages.pop_front();
                    if (i_out_index != want.index)
                        report_mismatch("out_index", i_out_index, want.index);
                    if (i_avg_red != want.red)
                        report_mismatch("avg_red", i_avg_red, want.red);
                    if (i_avg_green != want.green)
                        report_mismatch("avg_green", i_avg_green, want.green);
                    if (i_avg_blue != want.blue)
                        report_mismatch("avg_blue", i_avg_blue, want.blue);
                    if (i_used_count != want.count)
                        report_mismatch("used_count", i_used_count, want.count);
                end
            end
            if (i_cfg_we)
                gate_threshold = i_cfg_wdata;
            if (i_in_valid && !i_in_stall)
                predict_average(i_opcode, i_pixel_index, i_red, i_green, i_blue);
        end
        o_pending <= expected_averages.size();
    end

endmodule

FILE: tb/gated_temporal_pixel_average_core_test.sv
// Top of the gated temporal pixel average testbench: clock, reset, request stimulus,
// result stall pattern, watchdog and verdict. Depends on gtpa_pkg, the core and
// gtpa_average_checker, which does all prediction and comparison.
module gated_temporal_pixel_average_core_test;
    import gtpa_pkg::*;

    localparam int FRAME_PIXELS   = 262144;
    localparam int HALF_WINDOW    = 4;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 172;
    localparam int POOL_SIZE      = 6;
    localparam int DRAIN_CYCLES   = 12;
    localparam int HOLDOFF_CYCLES = 300;
    // The longest quiet stretch of a correct run is the long receiver hold-off
    // plus a drain pause and a random sender gap; this is well beyond that.
    localparam int WATCHDOG_LIMIT = 4000;

    // Opcode 3 has no meaning to the core and must be dropped.
    localparam logic [1:0] OP_IGNORED = 2'd3;

    logic             clk        = 1'b0;
    logic             rst_n      = 1'b0;
    logic             cfg_we     = 1'b0;
    logic [7:0]       cfg_wdata  = '0;
    logic             in_valid   = 1'b0;
    logic             in_stall;
    logic [1:0]       opcode     = '0;
    logic [IDX_W-1:0] pixel_index = '0;
    logic [7:0]       red        = '0;
    logic [7:0]       green      = '0;
    logic [7:0]       blue       = '0;
    logic             out_valid;
    logic             out_stall  = 1'b0;
    logic [IDX_W-1:0] out_index;
    logic [7:0]       avg_red;
    logic [7:0]       avg_green;
    logic [7:0]       avg_blue;
    logic [CNT_W-1:0] used_count;

    int fail_count;
    int pending;

    // Idling pattern of the current phase, in percent of cycles.
    int send_idle_pct = 0;
    int stall_pct     = 0;
    // Remaining cycles of a forced receiver hold-off.
    int holdoff_left  = 0;

    // Indexes that have seen a load, with the reference green they were loaded
    // with. Offers and reads only ever target these, so no unwritten entry is read.
    logic [IDX_W-1:0] pool_index     [POOL_SIZE];
    logic [7:0]       pool_ref_green [POOL_SIZE];
    logic [7:0]       cur_threshold = THRESHOLD_RESET;

    always #10 clk = ~clk;

    gated_temporal_pixel_average_core #(
        .FRAME_PIXELS (FRAME_PIXELS),
        .HALF_WINDOW  (HALF_WINDOW)
    ) dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_opcode      (opcode),
        .i_pixel_index (pixel_index),
        .i_red         (red),
        .i_green       (green),
        .i_blue        (blue),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_out_index   (out_index),
        .o_avg_red     (avg_red),
        .o_avg_green   (avg_green),
        .o_avg_blue    (avg_blue),
        .o_used_count  (used_count)
    );

    gtpa_average_checker #(
        .FRAME_PIXELS (FRAME_PIXELS),
        .HALF_WINDOW  (HALF_WINDOW)
    ) checker_i (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_opcode      (opcode),
        .i_pixel_index (pixel_index),
        .i_red         (red),
        .i_green       (green),
        .i_blue        (blue),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out_index   (out_index),
        .i_avg_red     (avg_red),
        .i_avg_green   (avg_green),
        .i_avg_blue    (avg_blue),
        .i_used_count  (used_count),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // Offers one request and returns at the rising edge that accepts it. Random
    // sender gaps come first, with valid low. Valid is left high on return, so
    // back-to-back requests keep it high without a glitch; drain_core lowers it.
    task automatic send_request(input logic [1:0] op, input logic [IDX_W-1:0] idx,
                                input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        opcode      <= op;
        pixel_index <= idx;
        red         <= r;
        green       <= g;
        blue        <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Loads a reference pixel and records it in the given pool slot.
    task automatic load_reference(input int slot, input logic [IDX_W-1:0] idx,
                                  input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        pool_index[slot]     = idx;
        pool_ref_green[slot] = g;
        send_request(OP_LOAD, idx, r, g, b);
    endtask

    // Stops offering, waits until every read has been answered, and then lets
    // the core finish any load or offer still in flight, which gives no result.
    task automatic drain_core();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // The threshold is only written while the core is quiet.
    task automatic write_threshold(input logic [7:0] value);
        drain_core();
        cfg_we        <= 1'b1;
        cfg_wdata     <= value;
        cur_threshold = value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Fresh indexes hit both ends of the range now and then so that the top and
    // bottom entries of the pixel memory see full sequences too.
    function automatic logic [IDX_W-1:0] pick_index();
        int sel;
        sel = $urandom_range(15);
        if (sel == 0)
            return '0;
        if (sel == 1)
            return IDX_W'(FRAME_PIXELS - 1);
        return IDX_W'($urandom_range(FRAME_PIXELS - 1));
    endfunction

    // One random request. Most of the traffic builds well-formed averages:
    // a load, offers whose green lands just inside or just outside the gate, and
    // reads. Reloads, reads before any offer, offers past the count capacity and
    // dropped opcodes make up the rest. Dropped requests do not count as items.
    task automatic send_random_request(output bit counted);
        int slot;
        int pick;
        int spread;
        int g;
        slot    = $urandom_range(POOL_SIZE - 1);
        pick    = $urandom_range(99);
        counted = 1'b1;
        if (pick < 12) begin
            load_reference(slot, pick_index(), 8'($urandom), 8'($urandom), 8'($urandom));
        end else if (pick < 17) begin
            load_reference(slot, pool_index[slot], 8'($urandom), 8'($urandom), 8'($urandom));
        end else if (pick < 70) begin
            if ($urandom_range(9) == 0) begin
                g = $urandom_range(255);
            end else begin
                spread = int'(cur_threshold) + 2;
                g = int'(pool_ref_green[slot]) + int'($urandom_range(2 * spread)) - spread;
                if (g < 0)
                    g = 0;
                if (g > 255)
                    g = 255;
            end
            send_request(OP_OFFER, pool_index[slot], 8'($urandom), 8'(g), 8'($urandom));
        end else if (pick < 95) begin
            send_request(OP_READ, pool_index[slot], 8'($urandom), 8'($urandom), 8'($urandom));
        end else begin
            counted = 1'b0;
            send_request(OP_IGNORED, IDX_W'($urandom), 8'($urandom), 8'($urandom),
                         8'($urandom));
        end
    endtask

    // Receiver side. A forced hold-off, counted down here, keeps the result
    // channel stalled long enough for the queue in the core to fill and push
    // back on the sender; otherwise the stall follows the phase's percentage.
    initial begin
        forever begin
            @(negedge clk);
            if (holdoff_left > 0) begin
                holdoff_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // The run is declared hung when no request, result or register write moves
    // for too long.
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        forever begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("gated_temporal_pixel_average_core verification failed");
                $finish;
            end
        end
    end

    initial begin
        logic [7:0] phase_threshold [PHASES];
        int         items;
        bit         counted;

        // Extremes of the gate first, then the reset value and assorted settings.
        phase_threshold[0] = 8'd0;
        phase_threshold[1] = 8'd255;
        phase_threshold[2] = THRESHOLD_RESET;
        phase_threshold[3] = 8'($urandom);
        phase_threshold[4] = 8'd1;
        phase_threshold[5] = 8'd254;
        phase_threshold[6] = 8'($urandom);
        phase_threshold[7] = 8'd128;

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, at the reset threshold of 20 and without idling.
        // Lowest index: neighbors exactly at the gate edge on both sides are
        // accepted, one a step beyond is rejected, and the read is repeated.
        load_reference(0, '0, 8'd255, 8'd100, 8'd0);
        send_request(OP_OFFER, '0, 8'd255, 8'd120, 8'd255);
        send_request(OP_OFFER, '0, 8'd0, 8'd79, 8'd0);
        send_request(OP_OFFER, '0, 8'd0, 8'd80, 8'd255);
        send_request(OP_READ, '0, 8'd0, 8'd0, 8'd0);
        send_request(OP_READ, '0, 8'd255, 8'd255, 8'd255);
        // Highest index at full scale: eight neighbors fill the count and the
        // last two offers find it saturated.
        load_reference(1, IDX_W'(FRAME_PIXELS - 1), 8'd0, 8'd255, 8'd255);
        repeat (10) send_request(OP_OFFER, IDX_W'(FRAME_PIXELS - 1), 8'd255, 8'd255, 8'd255);
        send_request(OP_READ, IDX_W'(FRAME_PIXELS - 1), 8'd0, 8'd0, 8'd0);
        // The unused opcode must leave every entry alone.
        send_request(OP_IGNORED, 18'h2AAAA, 8'h55, 8'hAA, 8'h55);
        send_request(OP_IGNORED, IDX_W'(FRAME_PIXELS - 1), 8'hFF, 8'hFF, 8'hFF);
        send_request(OP_READ, '0, 8'h55, 8'hAA, 8'h55);
        // Alternating bit patterns, with a reference green of zero.
        load_reference(2, 18'h15555, 8'h55, 8'h00, 8'hAA);
        send_request(OP_OFFER, 18'h15555, 8'hAA, 8'h00, 8'h55);
        send_request(OP_READ, 18'h15555, 8'hAA, 8'h55, 8'hAA);

        for (int s = 3; s < POOL_SIZE; s++) begin
            pool_index[s]     = pool_index[s - 3];
            pool_ref_green[s] = pool_ref_green[s - 3];
        end

        // Random phases. Each sets a new threshold while the core is quiet and
        // uses one of four idling patterns, so every pattern is seen twice.
        for (int p = 0; p < PHASES; p++) begin
            write_threshold(phase_threshold[p]);
            case (p % 4)
                0: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1: begin
                    send_idle_pct = 63;
                    stall_pct     = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct     = 63;
                end
                default: begin
                    send_idle_pct = 12;
                    stall_pct     = 12;
                end
            endcase
            // In one phase the receiver holds off for a long stretch while the
            // sender keeps offering at full rate.
            if (p == 4)
                holdoff_left = HOLDOFF_CYCLES;
            items = 0;
            while (items < PHASE_ITEMS) begin
                send_random_request(counted);
                if (counted)
                    items++;
            end
        end

        drain_core();
        if (fail_count == 0 && pending == 0)
            $display("gated_temporal_pixel_average_core verification clean");
        else
            $display("gated_temporal_pixel_average_core verification failed");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/gtpa_pkg.sv
rtl/core/gtpa_ram.sv
rtl/core/gtpa_front.sv
rtl/core/gtpa_back.sv
rtl/core/gated_temporal_pixel_average_core.sv
tb/gtpa_average_checker.sv
tb/gated_temporal_pixel_average_core_test.sv
